@@ hw/rtl/tekd_pkg.sv @@
// ----------------------------------------------------------------------------
// tekd_pkg
// Shared types, codes and constants of the terminal escape key decoder.
// ----------------------------------------------------------------------------
package tekd_pkg;

  localparam int PARAM_BITS_DEF = 16;
  localparam int OUT_DEPTH      = 4;

  localparam logic [1:0] FUNC_BYTE   = 2'd0;
  localparam logic [1:0] FUNC_TICK   = 2'd1;
  localparam logic [1:0] FUNC_RESIZE = 2'd2;

  localparam logic [2:0] KIND_PLAIN  = 3'd0;
  localparam logic [2:0] KIND_KEY    = 3'd1;
  localparam logic [2:0] KIND_MOUSE  = 3'd2;
  localparam logic [2:0] KIND_RESIZE = 3'd3;
  localparam logic [2:0] KIND_PBEGIN = 3'd4;
  localparam logic [2:0] KIND_PEND   = 3'd5;

  localparam logic [3:0] KEY_UP      = 4'd0;
  localparam logic [3:0] KEY_C_UP    = 4'd1;
  localparam logic [3:0] KEY_A_UP    = 4'd2;
  localparam logic [3:0] KEY_DOWN    = 4'd3;
  localparam logic [3:0] KEY_C_DOWN  = 4'd4;
  localparam logic [3:0] KEY_A_DOWN  = 4'd5;
  localparam logic [3:0] KEY_RIGHT   = 4'd6;
  localparam logic [3:0] KEY_C_RIGHT = 4'd7;
  localparam logic [3:0] KEY_LEFT    = 4'd8;
  localparam logic [3:0] KEY_C_LEFT  = 4'd9;
  localparam logic [3:0] KEY_HOME    = 4'd10;
  localparam logic [3:0] KEY_END     = 4'd11;
  localparam logic [3:0] KEY_DEL     = 4'd12;
  localparam logic [3:0] KEY_C_DEL   = 4'd13;
  localparam logic [3:0] KEY_PGUP    = 4'd14;
  localparam logic [3:0] KEY_PGDN    = 4'd15;

  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_O      = 8'h4F;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_M_UP   = 8'h4D;
  localparam logic [7:0] CH_M_LO   = 8'h6D;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_B      = 8'h42;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_D      = 8'h44;
  localparam logic [7:0] CH_F      = 8'h46;
  localparam logic [7:0] CH_H      = 8'h48;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;

  localparam int TILDE_HOME   = 1;
  localparam int TILDE_DEL    = 3;
  localparam int TILDE_END    = 4;
  localparam int TILDE_PGUP   = 5;
  localparam int TILDE_PGDN   = 6;
  localparam int TILDE_HOME2  = 7;
  localparam int TILDE_END2   = 8;
  localparam int TILDE_PBEGIN = 200;
  localparam int TILDE_PEND   = 201;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data_byte;
  } tekd_in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  char_value;
    logic [3:0]  key_id;
    logic        shift_flag;
    logic [15:0] mouse_button;
    logic [15:0] mouse_col;
    logic [15:0] mouse_row;
    logic        mouse_pressed;
    logic        last;
  } tekd_out_t;

  typedef struct packed {
    logic [1:0] cnt;
    tekd_out_t  r0;
    tekd_out_t  r1;
  } tekd_step_t;

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_ESC   = 6'b000010,
    PH_SS3   = 6'b000100,
    PH_CSI0  = 6'b001000,
    PH_CSI   = 6'b010000,
    PH_MOUSE = 6'b100000
  } tekd_phase_t;

  function automatic tekd_out_t mk_kind(input logic [2:0] kind);
    tekd_out_t r;
    r      = '0;
    r.kind = kind;
    return r;
  endfunction

  function automatic tekd_out_t mk_plain(input logic [7:0] b);
    tekd_out_t r;
    r            = mk_kind(KIND_PLAIN);
    r.char_value = b;
    return r;
  endfunction

  function automatic tekd_out_t mk_key(input logic [3:0] id, input logic shift);
    tekd_out_t r;
    r            = mk_kind(KIND_KEY);
    r.key_id     = id;
    r.shift_flag = shift;
    return r;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_0) && (b <= CH_9);
  endfunction

endpackage

@@ hw/rtl/tekd_decoder.sv @@
// ----------------------------------------------------------------------------
// tekd_decoder
// Sequence state and combinational decode of one item into up to two results.
// ----------------------------------------------------------------------------
module tekd_decoder
  import tekd_pkg::*;
#(
  parameter int PARAM_BITS = PARAM_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  tekd_in_t   item,
  output tekd_step_t res
);

  localparam logic [PARAM_BITS-1:0] PMAX = {PARAM_BITS{1'b1}};

  tekd_phase_t           phase_r, phase_nxt;
  logic [PARAM_BITS-1:0] pv_r   [3];
  logic [PARAM_BITS-1:0] pv_nxt [3];
  logic [1:0]            slot_r, slot_nxt;
  logic                  rw_r, rw_nxt;

  logic [7:0]            b;
  logic [3:0]            dig;
  logic [PARAM_BITS-1:0] zero_p;

  function automatic logic [PARAM_BITS-1:0] acc(input logic [PARAM_BITS-1:0] v,
                                                input logic [3:0] d);
    logic [PARAM_BITS+3:0] t;
    t = ({4'b0, v} << 3) + ({4'b0, v} << 1) + (PARAM_BITS + 4)'(d);
    return (t[PARAM_BITS+3:PARAM_BITS] != 4'd0) ? PMAX : t[PARAM_BITS-1:0];
  endfunction

  function automatic logic [15:0] sat16(input logic [PARAM_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic tekd_out_t csi_final(input logic [7:0] fin,
                                          input logic [PARAM_BITS-1:0] p0,
                                          input logic [PARAM_BITS-1:0] p1);
    logic [2:0] m;
    logic       ctrl;
    logic       alt;
    logic       hit;
    logic [3:0] id;
    tekd_out_t  r;
    m    = (p1 > PARAM_BITS'(1)) ? (p1[2:0] - 3'd1) : 3'd0;
    ctrl = m[2];
    alt  = m[1];
    hit  = 1'b1;
    id   = KEY_UP;
    r    = mk_plain(CH_ESC);
    priority if (fin == CH_A) begin
      id = ctrl ? KEY_C_UP : (alt ? KEY_A_UP : KEY_UP);
    end else if (fin == CH_B) begin
      id = ctrl ? KEY_C_DOWN : (alt ? KEY_A_DOWN : KEY_DOWN);
    end else if (fin == CH_C) begin
      id = ctrl ? KEY_C_RIGHT : KEY_RIGHT;
    end else if (fin == CH_D) begin
      id = ctrl ? KEY_C_LEFT : KEY_LEFT;
    end else if (fin == CH_H) begin
      id = KEY_HOME;
    end else if (fin == CH_F) begin
      id = KEY_END;
    end else if (fin == CH_TILDE) begin
      priority if (p0 == PARAM_BITS'(TILDE_HOME) || p0 == PARAM_BITS'(TILDE_HOME2)) begin
        id = KEY_HOME;
      end else if (p0 == PARAM_BITS'(TILDE_END) || p0 == PARAM_BITS'(TILDE_END2)) begin
        id = KEY_END;
      end else if (p0 == PARAM_BITS'(TILDE_DEL)) begin
        id = ctrl ? KEY_C_DEL : KEY_DEL;
      end else if (p0 == PARAM_BITS'(TILDE_PGUP)) begin
        id = KEY_PGUP;
      end else if (p0 == PARAM_BITS'(TILDE_PGDN)) begin
        id = KEY_PGDN;
      end else begin
        hit = 1'b0;
      end
    end else begin
      hit = 1'b0;
    end
    if (hit) begin
      r = mk_key(id, m[0]);
    end
    if (fin == CH_TILDE && p0 == PARAM_BITS'(TILDE_PBEGIN)) begin
      r = mk_kind(KIND_PBEGIN);
    end
    if (fin == CH_TILDE && p0 == PARAM_BITS'(TILDE_PEND)) begin
      r = mk_kind(KIND_PEND);
    end
    return r;
  endfunction

  assign b      = item.data_byte;
  assign dig    = b[3:0];
  assign zero_p = '0;

  always_comb begin
    phase_nxt = phase_r;
    pv_nxt    = pv_r;
    slot_nxt  = slot_r;
    rw_nxt    = rw_r;
    res.cnt   = 2'd0;
    res.r0    = mk_kind(KIND_PLAIN);
    res.r1    = mk_kind(KIND_PLAIN);
    if (step) begin
      unique case (item.func)
        FUNC_BYTE: begin
          unique case (phase_r)
            PH_IDLE: begin
              if (b == CH_ESC) begin
                phase_nxt = PH_ESC;
              end else begin
                res.r0  = mk_plain(b);
                res.cnt = 2'd1;
              end
            end
            PH_ESC: begin
              if (b == CH_O) begin
                phase_nxt = PH_SS3;
              end else if (b == CH_LBRACK) begin
                pv_nxt    = '{default: '0};
                slot_nxt  = 2'd0;
                phase_nxt = PH_CSI0;
              end else begin
                res.r0  = mk_plain(CH_ESC);
                res.cnt = 2'd1;
                if (b != CH_ESC) begin
                  phase_nxt = PH_IDLE;
                  res.r1    = mk_plain(b);
                  res.cnt   = 2'd2;
                end
              end
            end
            PH_SS3: begin
              phase_nxt = PH_IDLE;
              res.cnt   = 2'd1;
              if (b == CH_H) begin
                res.r0 = mk_key(KEY_HOME, 1'b0);
              end else if (b == CH_F) begin
                res.r0 = mk_key(KEY_END, 1'b0);
              end else begin
                res.r0 = mk_plain(CH_ESC);
              end
            end
            PH_CSI0: begin
              pv_nxt   = '{default: '0};
              slot_nxt = 2'd0;
              if (b == CH_LT) begin
                phase_nxt = PH_MOUSE;
              end else if (is_digit(b)) begin
                pv_nxt[0] = PARAM_BITS'(dig);
                phase_nxt = PH_CSI;
              end else if (b == CH_SEMI) begin
                slot_nxt  = 2'd1;
                phase_nxt = PH_CSI;
              end else begin
                res.r0    = csi_final(b, zero_p, zero_p);
                res.cnt   = 2'd1;
                phase_nxt = PH_IDLE;
              end
            end
            PH_CSI: begin
              if (is_digit(b)) begin
                if (slot_r < 2'd2) begin
                  pv_nxt[slot_r] = acc(pv_r[slot_r], dig);
                end
              end else if (b == CH_SEMI) begin
                if (slot_r < 2'd2) begin
                  slot_nxt = slot_r + 2'd1;
                end
              end else begin
                res.r0    = csi_final(b, pv_r[0], pv_r[1]);
                res.cnt   = 2'd1;
                phase_nxt = PH_IDLE;
              end
            end
            PH_MOUSE: begin
              if (is_digit(b)) begin
                if (slot_r <= 2'd2) begin
                  pv_nxt[slot_r] = acc(pv_r[slot_r], dig);
                end
              end else if (b == CH_SEMI) begin
                if (slot_r >= 2'd2) begin
                  phase_nxt = PH_IDLE;
                  res.r0    = mk_plain(CH_ESC);
                  res.cnt   = 2'd1;
                end else begin
                  slot_nxt = slot_r + 2'd1;
                end
              end else begin
                phase_nxt = PH_IDLE;
                res.cnt   = 2'd1;
                if (b == CH_M_UP || b == CH_M_LO) begin
                  res.r0               = mk_kind(KIND_MOUSE);
                  res.r0.mouse_button  = sat16(pv_r[0]);
                  res.r0.mouse_col     = sat16(pv_r[1]);
                  res.r0.mouse_row     = sat16(pv_r[2]);
                  res.r0.mouse_pressed = (b == CH_M_UP);
                end else begin
                  res.r0 = mk_plain(CH_ESC);
                end
              end
            end
            default: begin
              phase_nxt = PH_IDLE;
            end
          endcase
        end
        FUNC_TICK: begin
          if (phase_r == PH_IDLE) begin
            if (rw_r) begin
              rw_nxt  = 1'b0;
              res.r0  = mk_kind(KIND_RESIZE);
              res.cnt = 2'd1;
            end
          end else begin
            phase_nxt = PH_IDLE;
            res.r0    = mk_plain(CH_ESC);
            res.cnt   = 2'd1;
          end
        end
        FUNC_RESIZE: begin
          if (phase_r == PH_IDLE) begin
            rw_nxt  = 1'b0;
            res.r0  = mk_kind(KIND_RESIZE);
            res.cnt = 2'd1;
          end else begin
            rw_nxt = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    res.r0.last = (res.cnt == 2'd1);
    res.r1.last = (res.cnt == 2'd2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pv_r    <= '{default: '0};
      slot_r  <= 2'd0;
      rw_r    <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      pv_r    <= pv_nxt;
      slot_r  <= slot_nxt;
      rw_r    <= rw_nxt;
    end
  end

`ifndef SYNTH
  a_two_results_esc_first: assert property (@(posedge clk) disable iff (!rst_n)
    res.cnt == 2'd2 |-> res.r0.kind == KIND_PLAIN && res.r0.char_value == CH_ESC
                        && !res.r0.last && res.r1.last)
    else $error("two results without leading ESC");
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r != 2'd3)
    else $error("parameter slot out of range");
  a_resize_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res.cnt != 2'd0 && res.r0.kind == KIND_RESIZE |=> !rw_r)
    else $error("resize emitted but still waiting");
`endif

endmodule

@@ hw/rtl/tekd_out_fifo.sv @@
// ----------------------------------------------------------------------------
// tekd_out_fifo
// Result register queue: takes up to two results a cycle, gives one.
// ----------------------------------------------------------------------------
module tekd_out_fifo
  import tekd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  tekd_step_t push,
  output logic       room,
  output logic       out_valid,
  input  logic       out_stall,
  output tekd_out_t  out_data
);

  localparam int PW = $clog2(OUT_DEPTH);
  localparam int CW = $clog2(OUT_DEPTH + 1);

  tekd_out_t       mem_r [OUT_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            pop;
  logic [PW-1:0]   wr_ptr_p1;

  assign out_valid = (cnt_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign room      = (cnt_r <= CW'(OUT_DEPTH - 2));
  assign pop       = out_valid && !out_stall;
  assign wr_ptr_p1 = wr_ptr_r + PW'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PW'(push.cnt);
    rd_ptr_nxt = rd_ptr_r + PW'(pop);
    cnt_nxt    = cnt_r + CW'(push.cnt) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr_p1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt != 2'd0 |-> room)
    else $error("result queue overflow");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(OUT_DEPTH))
    else $error("result count above depth");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    PW'(wr_ptr_r - rd_ptr_r) == PW'(cnt_r))
    else $error("pointers disagree with count");
`endif

endmodule

@@ hw/rtl/terminal_escape_key_decoder_top.sv @@
// ----------------------------------------------------------------------------
// terminal_escape_key_decoder_top
// Decodes terminal input bytes, timeout ticks and resize events into key, character, mouse, resize and paste results.
// ----------------------------------------------------------------------------
// Path: input register, then decode once the result queue has room, then the result queue.
// Throughput: one request per cycle while the result queue has room; a request with two
//   results gives them out one at a time, through the single result read port of the queue.
// Reset: synchronous, active low; clears sequence state, parameters, pending
//   resize, the input register's full flag and the result queue.
module terminal_escape_key_decoder_top
  import tekd_pkg::*;
#(
  parameter int PARAM_BITS = PARAM_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  tekd_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output tekd_out_t out_data
);

  logic       in_full_r, in_full_nxt;
  tekd_in_t   in_item_r;
  logic       room;
  logic       proc;
  logic       in_acc;
  tekd_step_t res;

  assign proc        = in_full_r && room;
  assign in_stall    = in_full_r && !room;
  assign in_acc      = in_valid && !in_stall;
  assign in_full_nxt = in_acc || (in_full_r && !proc);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
    end else begin
      in_full_r <= in_full_nxt;
    end
  end

  tekd_decoder #(
    .PARAM_BITS(PARAM_BITS)
  ) u_dec (
    .clk  (clk),
    .rst_n(rst_n),
    .step (proc),
    .item (in_item_r),
    .res  (res)
  );

  tekd_out_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res),
    .room     (room),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

@@ tb/tekd_checker.sv @@
// ----------------------------------------------------------------------------
// tekd_checker
// Watches both channels of the terminal escape key decoder. Each accepted
// request runs through a behavioral copy of the decoder, which queues the
// results it should cause. Each accepted result is checked field by field
// against the oldest queued one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tekd_checker
  import tekd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  tekd_in_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  tekd_out_t out_data,
  output int        pending,
  output int        errors
);

  localparam int unsigned PARAM_MAX  = (1 << PARAM_BITS_DEF) - 1;
  localparam int          REPORT_CAP = 40;

  tekd_phase_t seq_phase;
  int unsigned param_val [3];
  int unsigned param_idx;
  logic        resize_held;
  tekd_out_t   step_res [$];
  tekd_out_t   key_events_q [$];
  int          fail_cnt;

  function automatic tekd_out_t make_res(input logic [2:0] kind, input logic [7:0] ch,
                                         input logic [3:0] key, input logic shift);
    tekd_out_t r;
    r            = '0;
    r.kind       = kind;
    r.char_value = ch;
    r.key_id     = key;
    r.shift_flag = shift;
    return r;
  endfunction

  task automatic push_esc();
    step_res.push_back(make_res(KIND_PLAIN, CH_ESC, '0, 1'b0));
  endtask

  task automatic clear_params();
    param_val[0] = 0;
    param_val[1] = 0;
    param_val[2] = 0;
    param_idx    = 0;
  endtask

  task automatic add_digit(input int unsigned slot, input logic [7:0] b);
    int unsigned v;
    if (slot <= 2) begin
      v = param_val[slot] * 10 + (b - CH_0);
      param_val[slot] = (v > PARAM_MAX) ? PARAM_MAX : v;
    end
  endtask

  task automatic take_idle_byte(input logic [7:0] b);
    if (b == CH_ESC)
      seq_phase = PH_ESC;
    else
      step_res.push_back(make_res(KIND_PLAIN, b, '0, 1'b0));
  endtask

  task automatic finish_csi(input logic [7:0] b);
    logic [2:0] modv;
    logic       ctrl;
    logic       alt;
    logic [3:0] key;
    logic       found;
    logic [2:0] kind;
    modv  = (param_val[1] >= 2) ? 3'((param_val[1] - 1) & 7) : 3'd0;
    ctrl  = modv[2];
    alt   = modv[1];
    found = 1'b1;
    key   = '0;
    kind  = KIND_KEY;
    seq_phase = PH_IDLE;
    case (b)
      CH_A: key = ctrl ? KEY_C_UP : alt ? KEY_A_UP : KEY_UP;
      CH_B: key = ctrl ? KEY_C_DOWN : alt ? KEY_A_DOWN : KEY_DOWN;
      CH_C: key = ctrl ? KEY_C_RIGHT : KEY_RIGHT;
      CH_D: key = ctrl ? KEY_C_LEFT : KEY_LEFT;
      CH_H: key = KEY_HOME;
      CH_F: key = KEY_END;
      CH_TILDE: begin
        case (param_val[0])
          TILDE_HOME, TILDE_HOME2: key = KEY_HOME;
          TILDE_END, TILDE_END2:   key = KEY_END;
          TILDE_DEL:               key = ctrl ? KEY_C_DEL : KEY_DEL;
          TILDE_PGUP:              key = KEY_PGUP;
          TILDE_PGDN:              key = KEY_PGDN;
          TILDE_PBEGIN:            kind = KIND_PBEGIN;
          TILDE_PEND:              kind = KIND_PEND;
          default:                 found = 1'b0;
        endcase
      end
      default: found = 1'b0;
    endcase
    if (kind != KIND_KEY)
      step_res.push_back(make_res(kind, '0, '0, 1'b0));
    else if (found)
      step_res.push_back(make_res(KIND_KEY, '0, key, modv[0]));
    else
      push_esc();
  endtask

  task automatic take_byte(input logic [7:0] b);
    logic      is_num;
    tekd_out_t r;
    is_num = (b >= CH_0) && (b <= CH_9);
    case (seq_phase)
      PH_IDLE: take_idle_byte(b);
      PH_ESC: begin
        if (b == CH_O) begin
          seq_phase = PH_SS3;
        end else if (b == CH_LBRACK) begin
          clear_params();
          seq_phase = PH_CSI0;
        end else begin
          push_esc();
          seq_phase = PH_IDLE;
          take_idle_byte(b);
        end
      end
      PH_SS3: begin
        seq_phase = PH_IDLE;
        if (b == CH_H)
          step_res.push_back(make_res(KIND_KEY, '0, KEY_HOME, 1'b0));
        else if (b == CH_F)
          step_res.push_back(make_res(KIND_KEY, '0, KEY_END, 1'b0));
        else
          push_esc();
      end
      PH_CSI0: begin
        clear_params();
        if (b == CH_LT) begin
          seq_phase = PH_MOUSE;
        end else if (is_num) begin
          param_val[0] = b - CH_0;
          seq_phase    = PH_CSI;
        end else if (b == CH_SEMI) begin
          param_idx = 1;
          seq_phase = PH_CSI;
        end else begin
          finish_csi(b);
        end
      end
      PH_CSI: begin
        if (is_num) begin
          if (param_idx < 2) add_digit(param_idx, b);
        end else if (b == CH_SEMI) begin
          if (param_idx < 2) param_idx++;
        end else begin
          finish_csi(b);
        end
      end
      PH_MOUSE: begin
        if (is_num) begin
          add_digit(param_idx, b);
        end else if (b == CH_SEMI) begin
          if (param_idx >= 2) begin
            seq_phase = PH_IDLE;
            push_esc();
          end else begin
            param_idx++;
          end
        end else begin
          seq_phase = PH_IDLE;
          if (b == CH_M_UP || b == CH_M_LO) begin
            r               = make_res(KIND_MOUSE, '0, '0, 1'b0);
            r.mouse_button  = 16'(param_val[0]);
            r.mouse_col     = 16'(param_val[1]);
            r.mouse_row     = 16'(param_val[2]);
            r.mouse_pressed = (b == CH_M_UP);
            step_res.push_back(r);
          end else begin
            push_esc();
          end
        end
      end
      default: seq_phase = PH_IDLE;
    endcase
  endtask

  task automatic predict(input tekd_in_t req);
    step_res.delete();
    case (req.func)
      FUNC_BYTE: take_byte(req.data_byte);
      FUNC_TICK: begin
        if (seq_phase == PH_IDLE) begin
          if (resize_held) begin
            resize_held = 1'b0;
            step_res.push_back(make_res(KIND_RESIZE, '0, '0, 1'b0));
          end
        end else begin
          seq_phase = PH_IDLE;
          push_esc();
        end
      end
      FUNC_RESIZE: begin
        if (seq_phase == PH_IDLE) begin
          resize_held = 1'b0;
          step_res.push_back(make_res(KIND_RESIZE, '0, '0, 1'b0));
        end else begin
          resize_held = 1'b1;
        end
      end
      default: ;
    endcase
    if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
    foreach (step_res[i]) key_events_q.push_back(step_res[i]);
  endtask

  task automatic cmp_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      if (fail_cnt < REPORT_CAP)
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      fail_cnt++;
    end
  endtask

  task automatic check_result(input tekd_out_t got);
    tekd_out_t want;
    if (key_events_q.size() == 0) begin
      if (fail_cnt < REPORT_CAP)
        $display("%0t: unexpected result: expected none, actual %p", $time, got);
      fail_cnt++;
    end else begin
      want = key_events_q.pop_front();
      cmp_field("kind", 16'(want.kind), 16'(got.kind));
      cmp_field("char_value", 16'(want.char_value), 16'(got.char_value));
      cmp_field("key_id", 16'(want.key_id), 16'(got.key_id));
      cmp_field("shift_flag", 16'(want.shift_flag), 16'(got.shift_flag));
      cmp_field("mouse_button", want.mouse_button, got.mouse_button);
      cmp_field("mouse_col", want.mouse_col, got.mouse_col);
      cmp_field("mouse_row", want.mouse_row, got.mouse_row);
      cmp_field("mouse_pressed", 16'(want.mouse_pressed), 16'(got.mouse_pressed));
      cmp_field("last", 16'(want.last), 16'(got.last));
    end
  endtask

  initial fail_cnt = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      seq_phase   = PH_IDLE;
      resize_held = 1'b0;
      clear_params();
      key_events_q.delete();
    end else begin
      // results first: a request accepted on this edge cannot have produced one yet
      if (out_valid && !out_stall) check_result(out_data);
      if (in_valid && !in_stall) predict(in_data);
    end
    pending <= key_events_q.size();
    errors  <= fail_cnt;
  end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Top of the terminal escape key decoder testbench. Drives a short directed
// set of requests, then random escape sequences (keys, mouse reports, SS3,
// paste markers) broken up by timeouts, resizes and noise, with bursty input
// and patterned output stalls. A checker beside the decoder scores results.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb
  import tekd_pkg::*;
;

  localparam logic [1:0] FUNC_UNUSED  = 2'd3;
  localparam int         RANDOM_ITEMS = 2000;
  localparam int         DRAIN_EVERY  = 500;
  localparam int         QUIET_LIMIT  = 2000;
  localparam int         TAIL_CYCLES  = 12;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_HALF,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  tekd_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  tekd_out_t out_data;

  int          pending;
  int          errors;
  int          burst_left   = 0;
  int          sent         = 0;
  int          quiet_cycles = 0;
  bit          noisy        = 1'b0;
  string       esc_str;
  string       tilde_codes [11] = '{"", "1", "2", "3", "4", "5", "6", "7", "8", "200", "201"};
  stall_mode_t stall_mode;
  int          mode_left    = 0;
  int          stall_tick   = 0;

  terminal_escape_key_decoder_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  tekd_checker u_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .pending  (pending),
    .errors   (errors)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      mode_left  = $urandom_range(20, 300);
    end
    mode_left--;
    stall_tick++;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_HALF:  out_stall <= ($urandom_range(0, 1) == 1);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= ((stall_tick % 7) < 4);
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic string one_char(input logic [7:0] c);
    string s;
    s = " ";
    s.putc(0, c);
    return s;
  endfunction

  function automatic string rand_num();
    string s;
    s = "";
    case ($urandom_range(0, 9))
      0: s = "";
      1, 2, 3, 4: s = $sformatf("%0d", $urandom_range(0, 9));
      5, 6: s = $sformatf("%0d", $urandom_range(10, 999));
      7: s = $sformatf("%0d", $urandom_range(1000, 65535));
      8: s = ($urandom_range(0, 1) == 1) ? "65535" : "65536";
      default: begin
        repeat ($urandom_range(5, 9)) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
      end
    endcase
    return s;
  endfunction

  function automatic string make_seq();
    string       s;
    string       mods;
    string       finals;
    int unsigned pick;
    int unsigned idx;
    pick = $urandom_range(0, 99);
    if (pick < 18) begin
      s = "";
      repeat ($urandom_range(1, 8))
        s = {s, one_char(($urandom_range(0, 9) == 0) ? CH_ESC : 8'($urandom_range(1, 255)))};
    end else if (pick < 50) begin
      mods   = ($urandom_range(0, 4) == 0) ? rand_num() : $sformatf("%0d", $urandom_range(0, 9));
      finals = "ABCDHF~~~";
      s      = {esc_str, "["};
      if ($urandom_range(0, 9) == 0) begin
        s = {s, ";", mods};
      end else begin
        idx = $urandom_range(0, 11);
        s   = {s, (idx == 11) ? rand_num() : tilde_codes[idx]};
        if ($urandom_range(0, 1) == 1) s = {s, ";", mods};
        if ($urandom_range(0, 7) == 0) s = {s, ";", rand_num()};
      end
      if ($urandom_range(0, 9) == 0)
        s = {s, one_char(8'($urandom_range(1, 255)))};
      else
        s = {s, one_char(finals.getc($urandom_range(0, finals.len() - 1)))};
    end else if (pick < 78) begin
      s = {esc_str, "[<", rand_num(), ";", rand_num()};
      if ($urandom_range(0, 9) != 0) s = {s, ";", rand_num()};
      if ($urandom_range(0, 9) == 0) s = {s, ";", rand_num()};
      if ($urandom_range(0, 9) == 0)
        s = {s, one_char(8'($urandom_range(1, 255)))};
      else
        s = {s, one_char(($urandom_range(0, 1) == 1) ? CH_M_UP : CH_M_LO)};
    end else if (pick < 90) begin
      case ($urandom_range(0, 2))
        0:       s = {esc_str, "O", one_char(CH_H)};
        1:       s = {esc_str, "O", one_char(CH_F)};
        default: s = {esc_str, "O", one_char(8'($urandom_range(1, 255)))};
      endcase
    end else begin
      s = {esc_str, one_char(8'($urandom_range(1, 255)))};
    end
    return s;
  endfunction

  // Bursts of back-to-back requests separated by random gaps; valid is only
  // lowered at the start of a gap or a drain, never in the step that raises it again.
  task automatic send_item(input logic [1:0] f, input logic [7:0] b);
    int       gap;
    tekd_in_t req;
    if (burst_left <= 0) begin
      if ($urandom_range(0, 9) == 0) begin
        gap        = 0;
        burst_left = $urandom_range(100, 300);
      end else begin
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        burst_left = $urandom_range(1, 16);
      end
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req.func      = f;
    req.data_byte = b;
    in_valid     <= 1'b1;
    in_data      <= req;
    do @(posedge clk); while (in_stall);
    if (f != FUNC_UNUSED) sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      if (noisy && $urandom_range(0, 49) == 0)
        send_item(($urandom_range(0, 1) == 1) ? FUNC_TICK : FUNC_RESIZE, 8'($urandom()));
      send_item(FUNC_BYTE, s.getc(i));
    end
  endtask

  task automatic drain();
    in_valid  <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    int unsigned pick;
    int          next_drain;
    string       seq;
    esc_str = one_char(CH_ESC);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, every function code, reprocessed byte, pending resize
    send_item(FUNC_RESIZE, 8'h00);
    send_item(FUNC_BYTE, 8'h00);
    send_item(FUNC_BYTE, 8'hFF);
    send_item(FUNC_UNUSED, 8'hAA);
    send_text({esc_str, "x"});
    send_text({esc_str, "OF"});
    send_text({esc_str, "[;3B"});
    send_text({esc_str, "[200~"});
    send_item(FUNC_BYTE, CH_ESC);
    send_item(FUNC_RESIZE, 8'h55);
    send_item(FUNC_TICK, 8'hFF);
    send_item(FUNC_TICK, 8'h00);
    drain();

    sent       = 0;
    noisy      = 1'b1;
    next_drain = DRAIN_EVERY;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        send_item(2'($urandom_range(0, 3)), 8'($urandom()));
      end else if (pick < 12) begin
        send_item(($urandom_range(0, 2) == 0) ? FUNC_RESIZE : FUNC_TICK, 8'($urandom()));
      end else begin
        seq = make_seq();
        if ($urandom_range(0, 11) == 0) begin
          seq = seq.substr(0, $urandom_range(0, seq.len() - 1));
          send_text(seq);
          send_item(FUNC_TICK, 8'($urandom()));
        end else begin
          send_text(seq);
        end
      end
      if (sent >= next_drain) begin
        drain();
        next_drain += DRAIN_EVERY;
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
